[rtl/atce_pkg.sv]
`timescale 1ns / 1ps

package atce_pkg;

   localparam int ATCE_MAX_DIM_DEFAULT = 1024;

   // Configuration port
   localparam int CSR_W     = 11;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_COLS    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_ROWS    = 2'd3;

   localparam logic [CSR_W-1:0] IMAGE_WIDTH_RESET  = 11'd80;
   localparam logic [CSR_W-1:0] IMAGE_HEIGHT_RESET = 11'd24;
   localparam logic [CSR_W-1:0] VIEW_COLS_RESET    = 11'd80;
   localparam logic [CSR_W-1:0] VIEW_ROWS_RESET    = 11'd24;

   // Text bytes
   localparam logic [7:0] CH_ESC     = 8'h1B;
   localparam logic [7:0] CH_NL      = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TILDE   = 8'h7E;
   localparam logic [7:0] CH_QUEST   = 8'h3F;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_TWO     = 8'h32;
   localparam logic [7:0] CH_THREE   = 8'h33;
   localparam logic [7:0] CH_FOUR    = 8'h34;
   localparam logic [7:0] CH_EIGHT   = 8'h38;
   localparam logic [7:0] CH_H       = 8'h48;
   localparam logic [7:0] CH_J       = 8'h4A;
   localparam logic [7:0] CH_M       = 8'h6D;

   // Output segments of one cell, in emission order
   localparam int SEG_COUNT = 8;
   localparam int SEG_W     = 3;

   typedef enum logic [SEG_W-1:0] {
      SEG_CLR_H  = 3'd0,
      SEG_CLR_3J = 3'd1,
      SEG_CLR_2J = 3'd2,
      SEG_NL     = 3'd3,
      SEG_FG     = 3'd4,
      SEG_BG     = 3'd5,
      SEG_GLYPH  = 3'd6,
      SEG_SGR0   = 3'd7
   } seg_type;

   typedef logic [SEG_COUNT-1:0] seg_mask_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef struct packed {
      logic [7:0] ch;
      logic [7:0] fg_red;
      logic [7:0] fg_green;
      logic [7:0] fg_blue;
      logic [7:0] bg_red;
      logic [7:0] bg_green;
      logic [7:0] bg_blue;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
   } rsp_payload_type;

   typedef struct packed {
      seg_mask_type mask;
      logic [7:0]   glyph;
      logic [23:0]  fg;
      logic [23:0]  bg;
   } job_type;

   function automatic seg_type first_seg(seg_mask_type m);
      seg_type r;
      r = SEG_CLR_H;
      for (int i = SEG_COUNT - 1; i >= 0; i--) begin
         if (m[i]) begin
            r = seg_type'(i[SEG_W-1:0]);
         end
      end
      return r;
   endfunction

   function automatic seg_mask_type seg_bit(seg_type s);
      return seg_mask_type'(1) << s;
   endfunction

   // Double dabble: 8-bit binary to three BCD digits
   function automatic logic [11:0] to_bcd(logic [7:0] v);
      logic [19:0] s;
      s = {12'd0, v};
      for (int i = 0; i < 8; i++) begin
         if (s[11:8] >= 4'd5) s[11:8] = s[11:8] + 4'd3;
         if (s[15:12] >= 4'd5) s[15:12] = s[15:12] + 4'd3;
         if (s[19:16] >= 4'd5) s[19:16] = s[19:16] + 4'd3;
         s = s << 1;
      end
      return s[19:8];
   endfunction

endpackage

[rtl/atce_front.sv]
`timescale 1ns / 1ps

module atce_front import atce_pkg::*; #(
   parameter int MAX_DIM = ATCE_MAX_DIM_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_payload_type      req_data,
   output logic                 q_push,
   output job_type              q_data,
   input  logic                 q_ready
);

   localparam int CW = $clog2(MAX_DIM);
   localparam int DW = (CW + 1 > CSR_W) ? CW + 1 : CSR_W;

   logic [CSR_W-1:0] image_width_ff, image_height_ff, view_cols_ff, view_rows_ff;
   logic [23:0]      last_fg_ff, last_bg_ff, last_fg_in, last_bg_in;
   logic [CW-1:0]    col_ff, row_ff, col_in, row_in;

   logic [DW-1:0] w_eff, h_eff, vc_eff, last_col, x_ext, y_ext, x_inc, y_inc;
   logic [23:0]   fg, bg;
   logic          accept, row_vis, col_vis, shown, ends_row, first_cell, x_zero;
   seg_mask_type  mask;
   logic [7:0]    glyph;

   assign req_ready = q_ready;
   assign accept    = req_valid && q_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMAGE_WIDTH_RESET;
         image_height_ff <= IMAGE_HEIGHT_RESET;
         view_cols_ff    <= VIEW_COLS_RESET;
         view_rows_ff    <= VIEW_ROWS_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
            CSR_VIEW_COLS:    view_cols_ff    <= csr_wdata;
            CSR_VIEW_ROWS:    view_rows_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      fg = {req_data.fg_red, req_data.fg_green, req_data.fg_blue};
      bg = {req_data.bg_red, req_data.bg_green, req_data.bg_blue};

      // Clamp image size to 1..MAX_DIM
      w_eff = DW'(image_width_ff);
      if (w_eff == '0) w_eff = DW'(1);
      else if (w_eff > DW'(MAX_DIM)) w_eff = DW'(MAX_DIM);
      h_eff = DW'(image_height_ff);
      if (h_eff == '0) h_eff = DW'(1);
      else if (h_eff > DW'(MAX_DIM)) h_eff = DW'(MAX_DIM);

      vc_eff   = (view_cols_ff == '0) ? DW'(1) : DW'(view_cols_ff);
      last_col = ((w_eff < vc_eff) ? w_eff : vc_eff) - DW'(1);

      x_ext      = DW'(col_ff);
      y_ext      = DW'(row_ff);
      x_zero     = (col_ff == '0);
      first_cell = x_zero && (row_ff == '0);
      row_vis    = y_ext < DW'(view_rows_ff);
      col_vis    = x_zero || (x_ext < DW'(view_cols_ff));
      shown      = row_vis && col_vis;
      ends_row   = shown && (x_ext == last_col);

      glyph = (req_data.ch >= CH_SPACE && req_data.ch <= CH_TILDE) ? req_data.ch : CH_QUEST;

      mask             = '0;
      mask[SEG_CLR_H]  = first_cell;
      mask[SEG_CLR_3J] = first_cell && !ends_row;
      mask[SEG_CLR_2J] = first_cell;
      mask[SEG_NL]     = shown && x_zero && (row_ff != '0);
      mask[SEG_FG]     = shown && (x_zero || (req_data.ch != CH_SPACE && fg != last_fg_ff));
      mask[SEG_BG]     = shown && (x_zero || bg != last_bg_ff);
      mask[SEG_GLYPH]  = shown;
      mask[SEG_SGR0]   = ends_row;

      q_push       = accept && (mask != '0);
      q_data.mask  = mask;
      q_data.glyph = glyph;
      q_data.fg    = fg;
      q_data.bg    = bg;

      last_fg_in = last_fg_ff;
      last_bg_in = last_bg_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      x_inc      = x_ext + DW'(1);
      y_inc      = y_ext + DW'(1);
      if (accept) begin
         if (mask[SEG_FG]) last_fg_in = fg;
         if (mask[SEG_BG]) last_bg_in = bg;
         if (x_inc >= w_eff) begin
            col_in = '0;
            row_in = (y_inc >= h_eff) ? '0 : y_inc[CW-1:0];
         end else begin
            col_in = x_inc[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_fg_ff <= '0;
         last_bg_ff <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
      end else begin
         last_fg_ff <= last_fg_in;
         last_bg_ff <= last_bg_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
      end
   end

endmodule

[rtl/atce_queue.sv]
`timescale 1ns / 1ps

module atce_queue import atce_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    push_ready,
   input  logic    pop,
   output job_type head,
   output logic    head_valid
);

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;

   assign head       = entry_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign push_ready = (count_ff != (QUEUE_AW + 1)'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = wr_ptr_ff + QUEUE_AW'(1);
      if (pop)  rd_ptr_in = rd_ptr_ff + QUEUE_AW'(1);
      if (push && !pop) count_in = count_ff + (QUEUE_AW + 1)'(1);
      else if (pop && !push) count_in = count_ff - (QUEUE_AW + 1)'(1);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/atce_back.sv]
`timescale 1ns / 1ps

module atce_back import atce_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  job_type         head,
   input  logic            head_valid,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   logic            active_ff, active_in;
   seg_type         seg_ff, seg_in;
   logic [4:0]      idx_ff, idx_in;
   seg_mask_type    mask_ff, mask_in;
   logic [7:0]      glyph_ff, glyph_in;
   logic [23:0]     fg_ff, fg_in, bg_ff, bg_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic        advance, last_byte, job_done;
   logic [7:0]  cur_byte, lead, comp, digit_ch;
   logic [23:0] rgb;
   logic [11:0] bcd;
   logic [3:0]  digit;
   seg_type     head_seg;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Byte at the current position of the current segment
   always_comb begin
      lead = (seg_ff == SEG_FG) ? CH_THREE : CH_FOUR;
      rgb  = (seg_ff == SEG_FG) ? fg_ff : bg_ff;
      if (idx_ff <= 5'd9) comp = rgb[23:16];
      else if (idx_ff <= 5'd13) comp = rgb[15:8];
      else comp = rgb[7:0];
      bcd = to_bcd(comp);
      if (idx_ff == 5'd7 || idx_ff == 5'd11 || idx_ff == 5'd15) digit = bcd[11:8];
      else if (idx_ff == 5'd8 || idx_ff == 5'd12 || idx_ff == 5'd16) digit = bcd[7:4];
      else digit = bcd[3:0];
      digit_ch = CH_ZERO | {4'd0, digit};

      cur_byte  = CH_ESC;
      last_byte = 1'b0;
      unique case (seg_ff) inside
         SEG_CLR_H: begin
            last_byte = (idx_ff == 5'd2);
            unique case (idx_ff) inside
               5'd0:    cur_byte = CH_ESC;
               5'd1:    cur_byte = CH_LBRACK;
               default: cur_byte = CH_H;
            endcase
         end
         SEG_CLR_3J, SEG_CLR_2J: begin
            last_byte = (idx_ff == 5'd3);
            unique case (idx_ff) inside
               5'd0:    cur_byte = CH_ESC;
               5'd1:    cur_byte = CH_LBRACK;
               5'd2:    cur_byte = (seg_ff == SEG_CLR_3J) ? CH_THREE : CH_TWO;
               default: cur_byte = CH_J;
            endcase
         end
         SEG_NL: begin
            last_byte = 1'b1;
            cur_byte  = CH_NL;
         end
         SEG_FG, SEG_BG: begin
            last_byte = (idx_ff == 5'd18);
            unique case (idx_ff) inside
               5'd0:                       cur_byte = CH_ESC;
               5'd1:                       cur_byte = CH_LBRACK;
               5'd2:                       cur_byte = lead;
               5'd3:                       cur_byte = CH_EIGHT;
               5'd4, 5'd6, 5'd10, 5'd14:   cur_byte = CH_SEMI;
               5'd5:                       cur_byte = CH_TWO;
               5'd18:                      cur_byte = CH_M;
               default:                    cur_byte = digit_ch;
            endcase
         end
         SEG_GLYPH: begin
            last_byte = 1'b1;
            cur_byte  = glyph_ff;
         end
         SEG_SGR0: begin
            last_byte = (idx_ff == 5'd2);
            unique case (idx_ff) inside
               5'd0:    cur_byte = CH_ESC;
               5'd1:    cur_byte = CH_LBRACK;
               default: cur_byte = CH_M;
            endcase
         end
         default: ;
      endcase
   end

   always_comb begin
      advance  = active_ff && (!rsp_valid_ff || rsp_ready);
      job_done = last_byte && (mask_ff == '0);
      pop      = head_valid && (!active_ff || (advance && job_done));
      head_seg = first_seg(head.mask);

      active_in    = active_ff;
      seg_in       = seg_ff;
      idx_in       = idx_ff;
      mask_in      = mask_ff;
      glyph_in     = glyph_ff;
      fg_in        = fg_ff;
      bg_in        = bg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (advance) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.out_byte = cur_byte;
         rsp_data_in.run_end  = job_done;
         if (!last_byte) begin
            idx_in = idx_ff + 5'd1;
         end else if (!job_done) begin
            seg_in  = first_seg(mask_ff);
            mask_in = mask_ff & ~seg_bit(first_seg(mask_ff));
            idx_in  = '0;
         end else begin
            active_in = 1'b0;
         end
      end

      // Take the next cell when idle or as soon as the current one has handed over its last byte
      if (pop) begin
         active_in = 1'b1;
         seg_in    = head_seg;
         mask_in   = head.mask & ~seg_bit(head_seg);
         idx_in    = '0;
         glyph_in  = head.glyph;
         fg_in     = head.fg;
         bg_in     = head.bg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         seg_ff       <= SEG_CLR_H;
         idx_ff       <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         seg_ff       <= seg_in;
         idx_ff       <= idx_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      glyph_ff    <= glyph_in;
      fg_ff       <= fg_in;
      bg_ff       <= bg_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[rtl/ansi_truecolor_cell_encoder_core.sv]
`timescale 1ns / 1ps

// Character cell to ANSI 24-bit color text encoder.
// req_*: one cell per transfer (character and RGB fore/background), in raster
//   order; the frame position is tracked internally from image_width/height.
// rsp_*: one text byte per transfer; run_end marks the last byte of a cell.
//   Clipped cells give no bytes, except the frame clear of a frame's first cell.
// csr_*: write-only registers 0..3 (image_width, image_height, view_cols,
//   view_rows); write only while the block is idle.
// The output sequencer emits one byte per cycle unless rsp_ready holds it; a
// plain glyph is one byte, a frame start with full color sequences up to 50. The
// front classifies one cell per cycle while the queue has room, and a four-cell
// queue decouples it, so short cells stream at one per cycle while rsp_ready is
// high. A cell's first byte passes the queue entry, sequencer state and output register.
// Reset restores the register defaults (80, 24, 80, 24), clears the position
// and the remembered colors and empties the queue. When rsp_ready is low the
// current byte holds; the queue fills and then req_ready drops.
module ansi_truecolor_cell_encoder_core import atce_pkg::*; #(
   parameter int MAX_DIM = ATCE_MAX_DIM_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_payload_type      req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_payload_type      rsp_data
);

   logic    q_push, q_ready, q_pop, q_valid;
   job_type q_in, q_head;

   atce_front #(
      .MAX_DIM(MAX_DIM)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .q_push       (q_push),
      .q_data       (q_in),
      .q_ready      (q_ready)
   );

   atce_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_in),
      .push_ready (q_ready),
      .pop        (q_pop),
      .head       (q_head),
      .head_valid (q_valid)
   );

   atce_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .head_valid (q_valid),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

[tb/tb_ansi_truecolor_cell_encoder_core.sv]
`timescale 1ns / 1ps

module tb_ansi_truecolor_cell_encoder_core;
   import atce_pkg::*;

   localparam int IDLE_PCT      = 19;
   localparam int LONG_STALL    = 400;
   localparam int SETTLE_CYCLES = 64;
   localparam int MAX_REPORTS   = 20;

   typedef struct {
      req_payload_type item;
      bit              drain_first;
   } pending_item_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_W-1:0]     csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_payload_type      req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_payload_type      rsp_data;

   // Register copies and encoder state for the prediction
   logic [CSR_W-1:0] width_reg  = IMAGE_WIDTH_RESET;
   logic [CSR_W-1:0] height_reg = IMAGE_HEIGHT_RESET;
   logic [CSR_W-1:0] vcols_reg  = VIEW_COLS_RESET;
   logic [CSR_W-1:0] vrows_reg  = VIEW_ROWS_RESET;
   logic [23:0]      shown_fg   = '0;
   logic [23:0]      shown_bg   = '0;
   logic [9:0]       cur_col    = '0;
   logic [9:0]       cur_row    = '0;

   pending_item_type cell_q[$];
   rsp_payload_type  text_q[$];

   int  cells_queued   = 0;
   int  cells_accepted = 0;
   int  bytes_checked  = 0;
   int  fail_count     = 0;
   int  settings_run   = 0;
   bit  steady_flow    = 1'b0;
   int  stall_requests = 0;
   int  stall_served   = 0;
   int  stall_left     = 0;

   ansi_truecolor_cell_encoder_core uut (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned clamp_size(logic [CSR_W-1:0] v);
      if (v == 0) return 1;
      if (v > ATCE_MAX_DIM_DEFAULT) return ATCE_MAX_DIM_DEFAULT;
      return 32'(v);
   endfunction

   function automatic void push_text(logic [7:0] b);
      rsp_payload_type r;
      r.out_byte = b;
      r.run_end  = 1'b0;
      text_q = {text_q, r};
   endfunction

   function automatic void push_decimal(logic [7:0] v);
      push_text(CH_ZERO + 8'(v / 100));
      push_text(CH_ZERO + 8'((v % 100) / 10));
      push_text(CH_ZERO + 8'(v % 10));
   endfunction

   function automatic void push_sgr_color(logic [7:0] lead, logic [23:0] rgb);
      push_text(CH_ESC);
      push_text(CH_LBRACK);
      push_text(lead);
      push_text(CH_EIGHT);
      push_text(CH_SEMI);
      push_text(CH_TWO);
      push_text(CH_SEMI);
      push_decimal(rgb[23:16]);
      push_text(CH_SEMI);
      push_decimal(rgb[15:8]);
      push_text(CH_SEMI);
      push_decimal(rgb[7:0]);
      push_text(CH_M);
   endfunction

   // Work out the text bytes of one accepted cell and advance the position
   function automatic void encode_cell(req_payload_type c);
      int unsigned w, h, vc, last_col, x, y;
      int          first;
      logic [23:0] fg, bg;
      logic [7:0]  glyph;
      bit          row_vis, col_vis, shown, ends_row;
      first    = text_q.size();
      fg       = {c.fg_red, c.fg_green, c.fg_blue};
      bg       = {c.bg_red, c.bg_green, c.bg_blue};
      w        = clamp_size(width_reg);
      h        = clamp_size(height_reg);
      vc       = (vcols_reg == 0) ? 1 : vcols_reg;
      last_col = ((w < vc) ? w : vc) - 1;
      x        = cur_col;
      y        = cur_row;
      row_vis  = y < vrows_reg;
      col_vis  = (x == 0) || (x < vcols_reg);
      shown    = row_vis && col_vis;
      ends_row = shown && (x == last_col);
      glyph    = (c.ch >= CH_SPACE && c.ch <= CH_TILDE) ? c.ch : CH_QUEST;

      if (x == 0 && y == 0) begin
         push_text(CH_ESC);
         push_text(CH_LBRACK);
         push_text(CH_H);
         // drop the scrollback clear when the cell also closes its row
         if (!ends_row) begin
            push_text(CH_ESC);
            push_text(CH_LBRACK);
            push_text(CH_THREE);
            push_text(CH_J);
         end
         push_text(CH_ESC);
         push_text(CH_LBRACK);
         push_text(CH_TWO);
         push_text(CH_J);
      end

      if (shown) begin
         if (x == 0) begin
            if (y != 0) push_text(CH_NL);
            shown_fg = fg;
            push_sgr_color(CH_THREE, fg);
            shown_bg = bg;
            push_sgr_color(CH_FOUR, bg);
         end else begin
            if (c.ch != CH_SPACE && fg != shown_fg) begin
               shown_fg = fg;
               push_sgr_color(CH_THREE, fg);
            end
            if (bg != shown_bg) begin
               shown_bg = bg;
               push_sgr_color(CH_FOUR, bg);
            end
         end
         push_text(glyph);
         if (ends_row) begin
            push_text(CH_ESC);
            push_text(CH_LBRACK);
            push_text(CH_M);
         end
      end

      if (text_q.size() > first) text_q[$].run_end = 1'b1;

      x++;
      if (x >= w) begin
         x = 0;
         y++;
         if (y >= h) y = 0;
      end
      cur_col = x[9:0];
      cur_row = y[9:0];
   endfunction

   // Sender: hold each cell until its transfer, idle at random, drain before drain_first cells
   always @(posedge clock) begin
      pending_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (cell_q.size() != 0 && (steady_flow || $urandom_range(99) >= IDLE_PCT) &&
             !(cell_q[0].drain_first && (req_valid || text_q.size() != 0))) begin
            nxt = cell_q.pop_front();
            req_valid <= 1'b1;
            req_data  <= nxt.item;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: check each byte transfer, predict each cell transfer
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            bytes_checked++;
            if (text_q.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: byte %h run_end %b with nothing expected",
                           $time, rsp_data.out_byte, rsp_data.run_end);
            end else begin
               want = text_q.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("%0t: out_byte expected %h, got %h",
                              $time, want.out_byte, rsp_data.out_byte);
               end
               if (rsp_data.run_end !== want.run_end) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("%0t: run_end expected %b, got %b",
                              $time, want.run_end, rsp_data.run_end);
               end
            end
         end
         if (req_valid && req_ready) begin
            cells_accepted++;
            encode_cell(req_data);
         end
         if (stall_served != stall_requests) begin
            stall_served = stall_requests;
            stall_left   = LONG_STALL;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   function automatic void queue_cell(logic [7:0] ch, logic [23:0] fg, logic [23:0] bg,
                                      bit drain_first);
      pending_item_type p;
      p.item        = {ch, fg, bg};
      p.drain_first = drain_first;
      cell_q = {cell_q, p};
      cells_queued++;
   endfunction

   function automatic logic [23:0] next_color(logic [23:0] prev);
      case ($urandom_range(6))
         0, 1, 2, 3: return prev;
         4:          return 24'h000000;
         5:          return 24'hFFFFFF;
         default:    return 24'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] next_char();
      case ($urandom_range(7))
         0:       return CH_SPACE;
         1:       return 8'($urandom_range(255));
         2:       return 8'($urandom_range(255, 127));
         3:       return 8'($urandom_range(31));
         default: return 8'($urandom_range(126, 32));
      endcase
   endfunction

   // Colors mostly repeat so that the change detection gets exercised
   function automatic void queue_random_cells(int count, int drain_at);
      logic [23:0] fg, bg;
      fg = 24'($urandom);
      bg = 24'($urandom);
      for (int i = 0; i < count; i++) begin
         fg = next_color(fg);
         bg = next_color(bg);
         queue_cell(next_char(), fg, bg, i == drain_at);
      end
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH:  width_reg  = val;
         CSR_IMAGE_HEIGHT: height_reg = val;
         CSR_VIEW_COLS:    vcols_reg  = val;
         default:          vrows_reg  = val;
      endcase
   endtask

   task automatic set_view(input int w, input int h, input int vc, input int vr);
      write_reg(CSR_IMAGE_WIDTH, CSR_W'(w));
      write_reg(CSR_IMAGE_HEIGHT, CSR_W'(h));
      write_reg(CSR_VIEW_COLS, CSR_W'(vc));
      write_reg(CSR_VIEW_ROWS, CSR_W'(vr));
      settings_run++;
   endtask

   // Sample at the falling edge so every update of the rising edge has landed
   task automatic wait_idle();
      do @(negedge clock);
      while (cells_accepted != cells_queued || text_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry: frame clear, full row start, color changes, odd characters
      settings_run++;
      queue_cell("A", 24'h000000, 24'hFFFFFF, 1'b0);
      queue_cell(8'h00, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
      queue_cell(8'hFF, 24'hFFFFFF, 24'h000000, 1'b0);
      queue_cell(CH_SPACE, 24'h123456, 24'h000000, 1'b0);
      queue_cell(8'h1F, 24'h123456, 24'h000000, 1'b0);
      queue_cell(CH_TILDE, 24'h123456, 24'h80FF01, 1'b0);
      queue_cell(8'h7F, 24'h123456, 24'h80FF01, 1'b0);
      wait_idle();

      // Shrink mid-row: clipping, row terminator, newline, hidden rows, new frame
      set_view(4, 3, 2, 2);
      queue_cell("b", 24'h0000FF, 24'h00FF00, 1'b0);
      queue_cell("c", 24'h0000FF, 24'h00FF00, 1'b0);
      queue_cell("d", 24'hFF0000, 24'h00FF00, 1'b0);
      queue_cell("e", 24'hFF0000, 24'h000000, 1'b0);
      queue_cell("f", 24'h00FF00, 24'hFF0000, 1'b0);
      for (int i = 0; i < 5; i++)
         queue_cell("g", 24'($urandom), 24'($urandom), 1'b0);
      queue_cell(CH_SPACE, 24'hABCDEF, 24'hFEDCBA, 1'b0);
      queue_cell("~", 24'h010203, 24'hFEDCBA, 1'b1);
      wait_idle();

      // Zero size acts as one: once the position wraps, each cell starts a frame and closes its row
      set_view(0, 0, 5, 1);
      queue_cell("x", 24'hFFFFFF, 24'h000000, 1'b0);
      queue_cell(8'h80, 24'h000000, 24'hFFFFFF, 1'b0);
      wait_idle();

      // No visible rows: only the frame clear comes out
      set_view(2, 2, 0, 0);
      for (int i = 0; i < 4; i++)
         queue_cell("z", 24'($urandom), 24'($urandom), 1'b0);
      wait_idle();

      // Fill the block while the receiver holds off
      set_view(8, 4, 6, 3);
      queue_random_cells(20, -1);
      stall_requests++;
      wait_idle();

      set_view(5, 3, 5, 3);
      steady_flow = 1'b1;
      queue_random_cells(20, -1);
      wait_idle();
      steady_flow = 1'b0;

      set_view(2047, 2047, 2047, 2047);
      queue_random_cells(12, -1);
      wait_idle();

      set_view(1024, 1, 1024, 1024);
      queue_random_cells(12, 6);
      wait_idle();

      set_view(3, 2, 0, 1);
      queue_random_cells(15, -1);
      wait_idle();

      for (int p = 0; p < 3; p++) begin
         set_view($urandom_range(9, 1), $urandom_range(5, 1),
                  $urandom_range(10, 0), $urandom_range(6, 0));
         queue_random_cells(15, 7);
         wait_idle();
      end

      $display("Encoded %0d cells into %0d checked bytes across %0d register settings",
               cells_accepted, bytes_checked, settings_run);
      $display("Covered frame clears, clipping, row ends, color reuse and a long stall");
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d bytes still expected", text_q.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule

[ansi_truecolor_cell_encoder_core.f]
rtl/atce_pkg.sv
rtl/atce_front.sv
rtl/atce_queue.sv
rtl/atce_back.sv
rtl/ansi_truecolor_cell_encoder_core.sv
tb/tb_ansi_truecolor_cell_encoder_core.sv
